// File: design/slist_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the sorted list block
// no dependencies
package slist_pkg;

	localparam int ValueW      = 31;
	localparam int ReqW        = 2;
	localparam int StatusW     = 3;
	localparam int DefCapacity = 64;

	// request kinds; the clear decode looks only at the high bit
	localparam logic [ReqW-1:0] REQ_INSERT = 2'd0;
	localparam logic [ReqW-1:0] REQ_REMOVE = 2'd1;
	localparam logic [ReqW-1:0] REQ_CLEAR  = 2'd2;

	localparam logic [StatusW-1:0] ST_INSERTED  = 3'd0;
	localparam logic [StatusW-1:0] ST_REMOVED   = 3'd1;
	localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [StatusW-1:0] ST_FULL      = 3'd3;
	localparam logic [StatusW-1:0] ST_CLEARED   = 3'd4;

	// command broadcast to every cell of the chain
	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_CMP  = 2'd1;
	localparam logic [1:0] CMD_INS  = 2'd2;
	localparam logic [1:0] CMD_REM  = 2'd3;

	typedef struct packed {
		logic [1:0]        op;
		logic [ValueW-1:0] value;
	} cmd_t;

endpackage

// File: design/slist_cell.sv
`timescale 1ns / 1ps
// one cell of the sorted chain: holds one entry and its compare flags
// depends on slist_pkg
module slist_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  logic                           clk,
	input  slist_pkg::cmd_t                cmd,
	input  logic [CW-1:0]                  count,
	input  logic [slist_pkg::ValueW-1:0]   left_entry,
	input  logic                           left_le,
	input  logic [slist_pkg::ValueW-1:0]   right_entry,
	output logic [slist_pkg::ValueW-1:0]   entry,
	output logic                           le,
	output logic                           lt,
	output logic                           eq
);

	logic [slist_pkg::ValueW-1:0] entry_q;
	logic                         le_q;
	logic                         lt_q;
	logic                         eq_q;
	logic                         valid;

	assign valid = count > CW'(IDX);

	always_ff @(posedge clk) begin
		case (cmd.op)
			slist_pkg::CMD_CMP: begin
				lt_q <= valid && (entry_q < cmd.value);
				le_q <= valid && (entry_q <= cmd.value);
				eq_q <= entry_q == cmd.value;
			end
			slist_pkg::CMD_INS: begin
				// first cell above the value takes it, the rest move up by one
				if (!le_q) begin
					entry_q <= left_le ? cmd.value : left_entry;
				end
			end
			slist_pkg::CMD_REM: begin
				if (!lt_q) begin
					entry_q <= right_entry;
				end
			end
			default: begin
			end
		endcase
	end

	assign entry = entry_q;
	assign le    = le_q;
	assign lt    = lt_q;
	assign eq    = eq_q;

endmodule

// File: design/slist_ctrl.sv
`timescale 1ns / 1ps
// request sequencer: compare broadcast, flag-row binary search, shift (insert/remove)
// depends on slist_pkg
module slist_ctrl #(
	parameter int CAPACITY = slist_pkg::DefCapacity,
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [slist_pkg::ReqW-1:0]    in_req,
	input  logic [slist_pkg::ValueW-1:0]  in_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [slist_pkg::StatusW-1:0] out_status,
	output logic [CW-1:0]                 out_pos,
	output logic [CW-1:0]                 out_count,
	output slist_pkg::cmd_t               cmd,
	output logic [CW-1:0]                 count,
	input  logic [CAPACITY-1:0]           le_vec,
	input  logic [CAPACITY-1:0]           lt_vec,
	input  logic [CAPACITY-1:0]           eq_vec
);

	localparam int IW = $clog2(CAPACITY);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SRCH = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]                    state_q;
	logic [slist_pkg::ReqW-1:0]    req_q;
	logic [slist_pkg::ValueW-1:0]  val_q;
	logic [CW-1:0]                 lo_q;
	logic [CW-1:0]                 hi_q;
	logic [CW-1:0]                 cnt_q;
	logic [slist_pkg::StatusW-1:0] st_q;
	logic [CW-1:0]                 pos_q;
	logic                          m_valid_q;
	logic [slist_pkg::StatusW-1:0] m_status_q;
	logic [CW-1:0]                 m_pos_q;
	logic [CW-1:0]                 m_cnt_q;

	logic          accept;
	logic          is_ins;
	logic [CW:0]   sum;
	logic [CW-1:0] mid;
	logic          mid_bit;
	logic          found;
	logic          load_out;

	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;
	assign is_ins   = req_q == slist_pkg::REQ_INSERT;
	assign sum      = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = sum[CW:1];
	// while lo is below hi, mid stays below hi, so it names a real cell
	assign mid_bit  = is_ins ? le_vec[mid[IW-1:0]] : lt_vec[mid[IW-1:0]];
	assign found    = (lo_q < cnt_q) && eq_vec[lo_q[IW-1:0]];
	assign load_out = (state_q == S_DONE) && (!m_valid_q || out_ready);

	always_comb begin
		cmd.op    = slist_pkg::CMD_NONE;
		cmd.value = val_q;
		if (accept && !in_req[1]
				&& !(in_req == slist_pkg::REQ_INSERT && cnt_q == CW'(CAPACITY))) begin
			cmd.op    = slist_pkg::CMD_CMP;
			cmd.value = in_value;
		end else if (state_q == S_SRCH && lo_q == hi_q) begin
			if (is_ins) begin
				cmd.op = slist_pkg::CMD_INS;
			end else if (found) begin
				cmd.op = slist_pkg::CMD_REM;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_req[1]) begin
							cnt_q   <= '0;
							state_q <= S_DONE;
						end else if (in_req == slist_pkg::REQ_INSERT
								&& cnt_q == CW'(CAPACITY)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					if (lo_q == hi_q) begin
						if (is_ins) begin
							cnt_q <= cnt_q + CW'(1);
						end else if (found) begin
							cnt_q <= cnt_q - CW'(1);
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_req;
			val_q <= in_value;
			lo_q  <= '0;
			hi_q  <= cnt_q;
			pos_q <= '0;
			if (in_req[1]) begin
				st_q <= slist_pkg::ST_CLEARED;
			end else begin
				st_q <= slist_pkg::ST_FULL;
			end
		end else if (state_q == S_SRCH) begin
			if (lo_q == hi_q) begin
				if (is_ins) begin
					st_q  <= slist_pkg::ST_INSERTED;
					pos_q <= lo_q;
				end else if (found) begin
					st_q  <= slist_pkg::ST_REMOVED;
					pos_q <= lo_q;
				end else begin
					st_q  <= slist_pkg::ST_NOT_FOUND;
				end
			end else if (mid_bit) begin
				lo_q <= mid + CW'(1);
			end else begin
				hi_q <= mid;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (out_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_status_q <= st_q;
			m_pos_q    <= pos_q;
			m_cnt_q    <= cnt_q;
		end
	end

	assign out_valid  = m_valid_q;
	assign out_status = m_status_q;
	assign out_pos    = m_pos_q;
	assign out_count  = m_cnt_q;
	assign count      = cnt_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SRCH |-> lo_q <= hi_q && hi_q <= cnt_q)
		else $error("search bounds crossed");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted item did not start work");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_status_q == slist_pkg::ST_CLEARED |-> m_cnt_q == '0)
		else $error("clear left entries");

	a_ins_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_status_q == slist_pkg::ST_INSERTED |-> m_pos_q < m_cnt_q)
		else $error("insert position outside the list");
`endif

endmodule

// File: design/sorted_list_insert_remove_core.sv
`timescale 1ns / 1ps
// sequence: clear and full-list insert go from accept straight to the done state; insert
// and remove broadcast a compare, binary search the cell flags, then shift (remove only if found)
// throughput: one item at a time, next item accepted the cycle after its result is loaded
// into the output register; an unread result holds the next request in its done state until read
// reset: arst_n empties the list at once (count zero), no clearing pass; entries stay
// undefined until written
module sorted_list_insert_remove_core #(
	parameter int CAPACITY = slist_pkg::DefCapacity,
	parameter int CW       = $clog2(CAPACITY + 1),
	parameter int OW       = ((2 * CW + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,  // value
	input  logic [slist_pkg::ReqW-1:0]    s_tuser,  // req_type
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [OW-1:0]                 m_tdata,  // position, count
	output logic [slist_pkg::StatusW-1:0] m_tuser   // status
);

	slist_pkg::cmd_t              cmd;
	logic [CW-1:0]                count;
	logic [CAPACITY-1:0]          le_vec;
	logic [CAPACITY-1:0]          lt_vec;
	logic [CAPACITY-1:0]          eq_vec;
	logic [slist_pkg::ValueW-1:0] entry_w [CAPACITY];
	logic [CW-1:0]                pos;
	logic [CW-1:0]                cnt_out;

	slist_ctrl #(
		.CAPACITY (CAPACITY),
		.CW       (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_req     (s_tuser),
		.in_value   (s_tdata[slist_pkg::ValueW-1:0]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_pos    (pos),
		.out_count  (cnt_out),
		.cmd        (cmd),
		.count      (count),
		.le_vec     (le_vec),
		.lt_vec     (lt_vec),
		.eq_vec     (eq_vec)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [slist_pkg::ValueW-1:0] left_entry;
		logic                         left_le;
		logic [slist_pkg::ValueW-1:0] right_entry;

		// cell zero sees an always-lower neighbor, the last cell reloads itself
		if (i == 0) begin : g_first
			assign left_entry = entry_w[i];
			assign left_le    = 1'b1;
		end else begin : g_mid
			assign left_entry = entry_w[i-1];
			assign left_le    = le_vec[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = entry_w[i];
		end else begin : g_inner
			assign right_entry = entry_w[i+1];
		end

		slist_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.count       (count),
			.left_entry  (left_entry),
			.left_le     (left_le),
			.right_entry (right_entry),
			.entry       (entry_w[i]),
			.le          (le_vec[i]),
			.lt          (lt_vec[i]),
			.eq          (eq_vec[i])
		);
	end

	assign m_tdata = OW'({cnt_out, pos});

endmodule
